FILE: sv/rbd_pkg.sv
// Shared constants, types and helper functions of the 2x2 box downscaler.
package rbd_pkg;

   // Largest supported output image size.
   localparam int MAX_OUT_WIDTH  = 512;
   localparam int MAX_OUT_HEIGHT = 512;

   // Field widths.
   localparam int SIZE_W = 10;
   localparam int CH_W   = 8;
   localparam int SUM_W  = CH_W + 1;
   localparam int NUM_CH = 3;
   localparam int LINE_W = NUM_CH * SUM_W;

   localparam int LINE_DEPTH  = MAX_OUT_WIDTH;
   localparam int LINE_ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SIZE_W-1:0] HALF_WIDTH_RST  = SIZE_W'(128);
   localparam logic [SIZE_W-1:0] HALF_HEIGHT_RST = SIZE_W'(128);

   typedef enum logic {
      REG_HALF_WIDTH  = 1'b0,
      REG_HALF_HEIGHT = 1'b1
   } reg_index_type;

   // Position information from the raster counters to the datapath.
   typedef struct packed {
      logic                   col_odd;
      logic                   row_odd;
      logic                   last_col;
      logic                   last_row;
      logic [LINE_ADDR_W-1:0] line_addr;
   } ctrl_type;

   // A size of zero acts as one, and a size above the maximum acts as the maximum.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] value,
                                                    input int                max_value);
      logic [SIZE_W-1:0] result;
      if (value == '0) begin
         result = SIZE_W'(1);
      end else if (int'(value) > max_value) begin
         result = SIZE_W'(max_value);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

FILE: sv/rgb_box_downscale_2x2_unit.sv
// Top level of the 2x2 box-filter downscaler for three-channel 8-bit pixels.
//
// Usage: pixels enter in raster order on the req_ channel, one word per pixel,
// with valid/ready handshake. The image is 2*half_width by 2*half_height pixels.
// Every pixel at an odd row and odd column produces one result word on the rsp_
// channel: the rounded mean of each channel over its 2x2 block. The last result
// of a frame carries rsp_frame_end. Other pixels produce no word.
// Three identical lanes, one per color, form the pair sums and means; a shared
// line store holds the pair sums of each even row for the odd row below it, and
// the output register merges the lanes into one result word.
// Throughput is one pixel per clock while the receiver keeps up. A result
// passes the registered line store read, then the output register. Reset sets
// both sizes to 128 and starts a new frame; the line store keeps no reset
// state, since each odd row only reads entries the row above wrote. Writing
// either size register also restarts the frame; the user must do it only while
// the block is idle, which the block itself does not enforce. When the receiver
// stalls, the result waits in the output register; one more word may wait in
// the read stage, after which req_ready drops until the receiver takes a word.
module rgb_box_downscale_2x2_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rbd_pkg::CH_W-1:0]       req_in_blue,
   input  logic [rbd_pkg::CH_W-1:0]       req_in_green,
   input  logic [rbd_pkg::CH_W-1:0]       req_in_red,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rbd_pkg::CH_W-1:0]       rsp_out_blue,
   output logic [rbd_pkg::CH_W-1:0]       rsp_out_green,
   output logic [rbd_pkg::CH_W-1:0]       rsp_out_red,
   output logic                           rsp_frame_end,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rbd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rbd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rbd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int NCH = rbd_pkg::NUM_CH;
   localparam int SW  = rbd_pkg::SUM_W;

   rbd_pkg::ctrl_type          ctrl;
   rbd_pkg::reg_index_type     csr_index;
   logic                       cfg_we;
   logic [rbd_pkg::SIZE_W-1:0] half_width;
   logic [rbd_pkg::SIZE_W-1:0] half_height;

   logic accept;
   logic load_first;
   logic line_read;
   logic line_write;
   logic out_free;
   logic s1_free;

   logic [rbd_pkg::CH_W-1:0]   pixel [NCH];
   logic [SW-1:0]              pair_sum [NCH];
   logic [rbd_pkg::CH_W-1:0]   mean [NCH];
   logic [rbd_pkg::LINE_W-1:0] line_wr_data;
   logic [rbd_pkg::LINE_W-1:0] line_rd_data;

   logic                     s1_valid_ff,     s1_valid_in;
   logic                     s1_frame_end_ff;
   logic                     out_valid_ff,    out_valid_in;
   logic                     out_frame_end_ff;
   logic [rbd_pkg::CH_W-1:0] out_blue_ff;
   logic [rbd_pkg::CH_W-1:0] out_green_ff;
   logic [rbd_pkg::CH_W-1:0] out_red_ff;

   // Configuration port: byte lanes are ignored, bit 2 selects the register.
   assign csr_pready = 1'b1;
   assign csr_index  = rbd_pkg::reg_index_type'(csr_paddr[2]);
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         rbd_pkg::REG_HALF_WIDTH:  csr_prdata = rbd_pkg::CSR_DATA_W'(half_width);
         rbd_pkg::REG_HALF_HEIGHT: csr_prdata = rbd_pkg::CSR_DATA_W'(half_height);
         default:                  csr_prdata = '0;
      endcase
   end

   // Handshake: the read stage moves on whenever the output register is free.
   assign out_free   = !out_valid_ff || rsp_ready;
   assign s1_free    = !s1_valid_ff || out_free;
   assign req_ready  = s1_free;
   assign accept     = req_valid && req_ready;
   assign load_first = accept && !ctrl.col_odd;
   assign line_write = accept && ctrl.col_odd && !ctrl.row_odd;
   assign line_read  = accept && ctrl.col_odd && ctrl.row_odd;

   rbd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .cfg_we      (cfg_we),
      .cfg_index   (csr_index),
      .cfg_data    (csr_pwdata[rbd_pkg::SIZE_W-1:0]),
      .half_width  (half_width),
      .half_height (half_height),
      .ctrl        (ctrl)
   );

   assign pixel[0] = req_in_blue;
   assign pixel[1] = req_in_green;
   assign pixel[2] = req_in_red;

   for (genvar k = 0; k < NCH; k++) begin : g_lane
      rbd_lane u_lane (
         .clock      (clock),
         .pixel      (pixel[k]),
         .load_first (load_first),
         .load_sum   (line_read),
         .above      (line_rd_data[k*SW +: SW]),
         .pair_sum   (pair_sum[k]),
         .mean       (mean[k])
      );
      assign line_wr_data[k*SW +: SW] = pair_sum[k];
   end

   rbd_ram #(
      .WIDTH (rbd_pkg::LINE_W),
      .DEPTH (rbd_pkg::LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_write),
      .wr_addr (ctrl.line_addr),
      .wr_data (line_wr_data),
      .rd_en   (line_read),
      .rd_addr (ctrl.line_addr),
      .rd_data (line_rd_data)
   );

   // Valid flags of the read stage and the output register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_free) begin
         s1_valid_in = line_read;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_read) begin
         s1_frame_end_ff <= ctrl.last_col && ctrl.last_row;
      end
      if (out_free && s1_valid_ff) begin
         out_blue_ff      <= mean[0];
         out_green_ff     <= mean[1];
         out_red_ff       <= mean[2];
         out_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_blue  = out_blue_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_red   = out_red_ff;
   assign rsp_frame_end = out_frame_end_ff;

endmodule

FILE: sv/rbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/rbd_lane.sv
// One color channel lane: horizontal pair sum and rounded mean of a 2x2 block.
module rbd_lane (
   input  logic                     clock,
   input  logic [rbd_pkg::CH_W-1:0] pixel,
   input  logic                     load_first,
   input  logic                     load_sum,
   input  logic [rbd_pkg::SUM_W-1:0] above,
   output logic [rbd_pkg::SUM_W-1:0] pair_sum,
   output logic [rbd_pkg::CH_W-1:0]  mean
);

   logic [rbd_pkg::CH_W-1:0]  first_ff;
   logic [rbd_pkg::SUM_W-1:0] sum_ff;
   logic [rbd_pkg::SUM_W+1:0] total;

   always_ff @(posedge clock) begin
      if (load_first) begin
         first_ff <= pixel;
      end
      if (load_sum) begin
         sum_ff <= pair_sum;
      end
   end

   assign pair_sum = rbd_pkg::SUM_W'(first_ff) + rbd_pkg::SUM_W'(pixel);

   // Four samples plus two, divided by four. The total stays below 1024, so
   // the mean fits in one channel.
   assign total = (rbd_pkg::SUM_W+2)'(above) + (rbd_pkg::SUM_W+2)'(sum_ff)
                + (rbd_pkg::SUM_W+2)'(2);
   assign mean  = total[rbd_pkg::SUM_W:2];

endmodule

FILE: sv/rbd_ctrl.sv
// Size registers and raster position counters of the 2x2 box downscaler.
module rbd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       cfg_we,
   input  rbd_pkg::reg_index_type     cfg_index,
   input  logic [rbd_pkg::SIZE_W-1:0] cfg_data,
   output logic [rbd_pkg::SIZE_W-1:0] half_width,
   output logic [rbd_pkg::SIZE_W-1:0] half_height,
   output rbd_pkg::ctrl_type          ctrl
);

   logic [rbd_pkg::SIZE_W-1:0] half_width_ff,  half_width_in;
   logic [rbd_pkg::SIZE_W-1:0] half_height_ff, half_height_in;
   logic [rbd_pkg::SIZE_W-1:0] column_ff,      column_in;
   logic [rbd_pkg::SIZE_W-1:0] row_ff,         row_in;
   logic                       col_odd_ff,     col_odd_in;
   logic                       row_odd_ff,     row_odd_in;

   logic [rbd_pkg::SIZE_W-1:0] width_eff;
   logic [rbd_pkg::SIZE_W-1:0] height_eff;
   logic [rbd_pkg::SIZE_W-1:0] col;
   logic                       last_col;
   logic                       last_row;

   always_comb begin
      width_eff  = rbd_pkg::clamp_size(half_width_ff,  rbd_pkg::MAX_OUT_WIDTH);
      height_eff = rbd_pkg::clamp_size(half_height_ff, rbd_pkg::MAX_OUT_HEIGHT);
      col        = (column_ff >= width_eff) ? (width_eff - 1'b1) : column_ff;
      last_col   = ((rbd_pkg::SIZE_W+1)'(col) + 1'b1) >= (rbd_pkg::SIZE_W+1)'(width_eff);
      last_row   = ((rbd_pkg::SIZE_W+1)'(row_ff) + 1'b1) >= (rbd_pkg::SIZE_W+1)'(height_eff);
   end

   always_comb begin
      half_width_in  = half_width_ff;
      half_height_in = half_height_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      col_odd_in     = col_odd_ff;
      row_odd_in     = row_odd_ff;
      if (cfg_we) begin
         // Any size write restarts the frame.
         if (cfg_index == rbd_pkg::REG_HALF_WIDTH) begin
            half_width_in = cfg_data;
         end else begin
            half_height_in = cfg_data;
         end
         column_in  = '0;
         row_in     = '0;
         col_odd_in = 1'b0;
         row_odd_in = 1'b0;
      end else if (advance) begin
         if (!col_odd_ff) begin
            col_odd_in = 1'b1;
         end else begin
            col_odd_in = 1'b0;
            if (last_col) begin
               column_in = '0;
               if (row_odd_ff) begin
                  row_odd_in = 1'b0;
                  row_in     = last_row ? '0 : (row_ff + 1'b1);
               end else begin
                  row_odd_in = 1'b1;
               end
            end else begin
               column_in = col + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= rbd_pkg::HALF_WIDTH_RST;
         half_height_ff <= rbd_pkg::HALF_HEIGHT_RST;
         column_ff      <= '0;
         row_ff         <= '0;
         col_odd_ff     <= 1'b0;
         row_odd_ff     <= 1'b0;
      end else begin
         half_width_ff  <= half_width_in;
         half_height_ff <= half_height_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         col_odd_ff     <= col_odd_in;
         row_odd_ff     <= row_odd_in;
      end
   end

   assign half_width     = half_width_ff;
   assign half_height    = half_height_ff;
   assign ctrl.col_odd   = col_odd_ff;
   assign ctrl.row_odd   = row_odd_ff;
   assign ctrl.last_col  = last_col;
   assign ctrl.last_row  = last_row;
   assign ctrl.line_addr = col[rbd_pkg::LINE_ADDR_W-1:0];

endmodule

FILE: tb/box_mean_checker.sv
// Channel monitor, 2x2 box-mean predictor and scoreboard for the downscaler.
module box_mean_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [rbd_pkg::CH_W-1:0]       req_in_blue,
   input  logic [rbd_pkg::CH_W-1:0]       req_in_green,
   input  logic [rbd_pkg::CH_W-1:0]       req_in_red,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [rbd_pkg::CH_W-1:0]       rsp_out_blue,
   input  logic [rbd_pkg::CH_W-1:0]       rsp_out_green,
   input  logic [rbd_pkg::CH_W-1:0]       rsp_out_red,
   input  logic                           rsp_frame_end,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rbd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rbd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [rbd_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import rbd_pkg::*;

   localparam logic [SIZE_W-1:0] SIZE_AFTER_RESET = SIZE_W'(128);
   localparam int                MAX_PRINTED      = 40;

   typedef logic [NUM_CH-1:0][SUM_W-1:0] channel_sums_type;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
      logic            frame_end;
   } box_mean_type;

   // Shadow of the size registers and of the raster position.
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;
   int                pair_col;
   int                pair_row;
   logic              on_odd_col;
   logic              on_odd_row;
   channel_sums_type  left_pixel;
   channel_sums_type  upper_pairs [MAX_OUT_WIDTH];

   box_mean_type      expected_means [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      for (int i = 0; i < MAX_OUT_WIDTH; i++) begin
         upper_pairs[i] = '0;
      end
   end

   function automatic int effective_size(input logic [SIZE_W-1:0] value, input int limit);
      int result;
      result = int'(value);
      if (result == 0) begin
         result = 1;
      end else if (result > limit) begin
         result = limit;
      end
      return result;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] size_readback(input reg_index_type which);
      logic [CSR_DATA_W-1:0] value;
      value = '0;
      case (which)
         REG_HALF_WIDTH: begin
            value[SIZE_W-1:0] = width_reg;
         end
         REG_HALF_HEIGHT: begin
            value[SIZE_W-1:0] = height_reg;
         end
      endcase
      return value;
   endfunction

   task automatic note_mismatch(input string what);
      fail_count++;
      if (fail_count <= MAX_PRINTED) begin
         $display("%0t: mismatch: %s", $realtime, what);
      end
   endtask

   task automatic restart_raster();
      pair_col   = 0;
      pair_row   = 0;
      on_odd_col = 1'b0;
      on_odd_row = 1'b0;
      left_pixel = '0;
   endtask

   // Channel order in px: blue, green, red.
   task automatic accept_pixel(input logic [NUM_CH-1:0][CH_W-1:0] px);
      int                          w;
      int                          h;
      int                          col;
      logic                        last_col;
      logic                        last_row;
      channel_sums_type            here;
      logic [NUM_CH-1:0][CH_W-1:0] avg;
      box_mean_type                mean;
      w   = effective_size(width_reg, MAX_OUT_WIDTH);
      h   = effective_size(height_reg, MAX_OUT_HEIGHT);
      col = (pair_col >= w) ? w - 1 : pair_col;
      if (!on_odd_col) begin
         for (int k = 0; k < NUM_CH; k++) begin
            left_pixel[k] = SUM_W'(px[k]);
         end
         on_odd_col = 1'b1;
      end else begin
         for (int k = 0; k < NUM_CH; k++) begin
            here[k] = left_pixel[k] + SUM_W'(px[k]);
         end
         last_col = (col + 1 >= w);
         last_row = (pair_row + 1 >= h);
         if (!on_odd_row) begin
            upper_pairs[col] = here;
         end else begin
            for (int k = 0; k < NUM_CH; k++) begin
               avg[k] = CH_W'((int'(upper_pairs[col][k]) + int'(here[k]) + 2) >> 2);
            end
            mean.blue      = avg[0];
            mean.green     = avg[1];
            mean.red       = avg[2];
            mean.frame_end = last_col && last_row;
            expected_means.push_back(mean);
         end
         on_odd_col = 1'b0;
         left_pixel = '0;
         if (last_col) begin
            pair_col = 0;
            if (on_odd_row) begin
               on_odd_row = 1'b0;
               pair_row   = last_row ? 0 : pair_row + 1;
            end else begin
               on_odd_row = 1'b1;
            end
         end else begin
            pair_col = col + 1;
         end
      end
   endtask

   always @(posedge clock) begin
      box_mean_type  want;
      reg_index_type which;
      if (reset) begin
         width_reg  = SIZE_AFTER_RESET;
         height_reg = SIZE_AFTER_RESET;
         restart_raster();
         expected_means.delete();
      end else begin
         which = reg_index_type'(csr_paddr[2]);
         if (csr_psel && csr_penable && csr_pready && csr_paddr[1:0] == 2'b00) begin
            if (csr_pwrite) begin
               if (which == REG_HALF_WIDTH) begin
                  width_reg = csr_pwdata[SIZE_W-1:0];
               end else begin
                  height_reg = csr_pwdata[SIZE_W-1:0];
               end
               restart_raster();
            end else if (csr_prdata !== size_readback(which)) begin
               note_mismatch($sformatf("register %s reads %0h, expected %0h",
                                       which.name(), csr_prdata, size_readback(which)));
            end
         end
         if (req_valid && req_ready) begin
            accept_pixel({req_in_red, req_in_green, req_in_blue});
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_means.size() == 0) begin
               note_mismatch("result word with no completed 2x2 block pending");
            end else begin
               want = expected_means.pop_front();
               if (rsp_out_blue !== want.blue) begin
                  note_mismatch($sformatf("blue %0d, expected %0d", rsp_out_blue, want.blue));
               end
               if (rsp_out_green !== want.green) begin
                  note_mismatch($sformatf("green %0d, expected %0d", rsp_out_green,
                                          want.green));
               end
               if (rsp_out_red !== want.red) begin
                  note_mismatch($sformatf("red %0d, expected %0d", rsp_out_red, want.red));
               end
               if (rsp_frame_end !== want.frame_end) begin
                  note_mismatch($sformatf("frame_end %0b, expected %0b", rsp_frame_end,
                                          want.frame_end));
               end
            end
         end
      end
      pending_count = expected_means.size();
   end

endmodule

FILE: tb/rgb_box_downscale_2x2_unit_test.sv
// Stimulus, flow control and verdict for the 2x2 box-filter downscaler.
module rgb_box_downscale_2x2_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rbd_pkg::*;

   // Direction codes for the register port.
   localparam logic CSR_WRITE = 1'b1;
   localparam logic CSR_READ  = 1'b0;

   // The receiver stops taking words for this many cycles once, early in the
   // random part, so the output register and the read stage fill and the block
   // has to push back on its input.
   localparam int LONG_HOLD = 200;

   // Random pixels after the directed part.
   localparam int RANDOM_PIXELS = 330;

   // Roughly 460 pixels are sent in all. Even if every pixel waited out the
   // longest sender gap and every result the longest receiver stall, the run
   // would stay well below this.
   localparam int CYCLE_LIMIT = 200_000;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [CH_W-1:0]       req_in_blue   = '0;
   logic [CH_W-1:0]       req_in_green  = '0;
   logic [CH_W-1:0]       req_in_red    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [CH_W-1:0]       rsp_out_blue;
   logic [CH_W-1:0]       rsp_out_green;
   logic [CH_W-1:0]       rsp_out_red;
   logic                  rsp_frame_end;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending_count;
   int cycle_count;

   // When steady is set, neither side starts a new idle stretch. hold_request asks the receiver
   // for the one long hold-off.
   logic steady       = 1'b0;
   logic hold_request = 1'b0;

   rgb_box_downscale_2x2_unit i_dut (.*);

   box_mean_checker i_checker (.*);

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle stretch lengths: mostly none or short, now and then a long one.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end
      if (pick < 85) begin
         return $urandom_range(1, 3);
      end
      if (pick < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Pixel channels lean toward the two extremes, since those are where a
   // carry out of the pair sum or the rounding would first go wrong.
   function automatic logic [CH_W-1:0] random_channel();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return '0;
      end
      if (pick == 1) begin
         return '1;
      end
      return CH_W'($urandom_range(0, 255));
   endfunction

   // Offers one pixel word after an optional idle gap and returns at the
   // rising edge at which the block takes it. The word stays on the bus until
   // then. Valid is lowered only when a gap follows, so it never drops and
   // rises within one time step.
   task automatic send_pixel(input logic [CH_W-1:0] blue, input logic [CH_W-1:0] green,
                             input logic [CH_W-1:0] red);
      int gap;
      gap = steady ? 0 : idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_in_blue  <= blue;
      req_in_green <= green;
      req_in_red   <= red;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_pixels(input int count);
      for (int i = 0; i < count; i++) begin
         send_pixel(random_channel(), random_channel(), random_channel());
      end
   endtask

   // One register transfer: setup cycle, then access cycle until pready.
   // The checker watches the port and checks the data of every read.
   task automatic csr_transfer(input logic is_write, input reg_index_type which,
                               input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_ADDR_W'({which, 2'b00});
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Stops the pixel stream and lets the block run dry. A pixel that makes no
   // result may still be in the pipeline when the last result has left, so the
   // task keeps waiting after no result is pending.
   task automatic finish_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // A size write restarts the frame, so it is made only while idle. The
   // value is read back right after.
   task automatic set_size(input reg_index_type which, input logic [CSR_DATA_W-1:0] data);
      finish_traffic();
      csr_transfer(CSR_WRITE, which, data);
      csr_transfer(CSR_READ, which, '0);
   endtask

   // Receiver. Each cycle it either sits in a stall or is ready, and when
   // ready it may start a new stall. The long hold-off is counted here.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) begin
               stall_left = idle_length();
            end
         end
      end
   end

   // A hung handshake or a result that never comes ends the run here.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rgb_box_downscale_2x2_unit_test: errors");
      $finish;
   end

   initial begin : stimulus
      int   ew;
      int   eh;
      int   frame_pixels;
      int   frames;
      int   count;
      int   random_sent;
      logic hold_armed;
      logic [SIZE_W-1:0] new_w;
      logic [SIZE_W-1:0] new_h;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Both sizes come up as 128. Read them back, then send the start of the
      // first row at that width. It gives no result, and the size write that
      // follows restarts the frame.
      csr_transfer(CSR_READ, REG_HALF_WIDTH, '0);
      csr_transfer(CSR_READ, REG_HALF_HEIGHT, '0);
      send_random_pixels(32);

      // A size of zero behaves as one, so each frame is a single 2x2 block
      // and every result ends its frame. The counters wrap between frames.
      set_size(REG_HALF_WIDTH, '0);
      set_size(REG_HALF_HEIGHT, '0);
      // Blue all zero, green all full scale, red sum of one rounds down.
      send_pixel(8'd0, 8'd255, 8'd1);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      // Blue full scale, green sum of two rounds up, red sum of six rounds up.
      send_pixel(8'd255, 8'd1, 8'd3);
      send_pixel(8'd255, 8'd1, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd1);

      // Two blocks side by side: the line store carries two pair sums and
      // only the second result ends the frame.
      set_size(REG_HALF_WIDTH, CSR_DATA_W'(2));
      set_size(REG_HALF_HEIGHT, CSR_DATA_W'(1));
      send_random_pixels(8);

      // Stop partway into a frame, with a left pixel held, and rewrite a
      // size. The next pixel has to start a fresh frame.
      send_random_pixels(3);
      set_size(REG_HALF_WIDTH, CSR_DATA_W'(1));
      send_pixel(8'd255, 8'd0, 8'd170);
      send_pixel(8'd0, 8'd255, 8'd85);
      send_pixel(8'd255, 8'd0, 8'd170);
      send_pixel(8'd0, 8'd255, 8'd85);

      // Random part: small sizes, mostly whole frames with random content,
      // some frames cut short by a size write. The first setting is wide
      // enough that the long receiver hold-off finds the sender still busy.
      random_sent = 0;
      hold_armed  = 1'b0;
      ew          = 1;
      eh          = 1;
      while (random_sent < RANDOM_PIXELS) begin
         if (!hold_armed) begin
            new_w = SIZE_W'(16);
         end else begin
            case ($urandom_range(0, 9))
               0:       new_w = '0;
               1:       new_w = SIZE_W'(1);
               7, 8:    new_w = SIZE_W'($urandom_range(7, 24));
               default: new_w = SIZE_W'($urandom_range(2, 6));
            endcase
         end
         new_h = ($urandom_range(0, 7) == 0) ? '0 : SIZE_W'($urandom_range(1, 3));
         steady = 1'b0;
         set_size(REG_HALF_WIDTH, (CSR_DATA_W'($urandom) << SIZE_W) | CSR_DATA_W'(new_w));
         ew = (new_w == 0) ? 1 : int'(new_w);
         if (!hold_armed || $urandom_range(0, 1) == 0) begin
            set_size(REG_HALF_HEIGHT, CSR_DATA_W'(new_h));
            eh = (new_h == 0) ? 1 : int'(new_h);
         end
         steady       = ($urandom_range(0, 3) == 0);
         frame_pixels = 4 * ew * eh;
         frames       = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            count = frame_pixels;
            if (f == frames - 1 && $urandom_range(0, 9) == 0) begin
               count = $urandom_range(1, frame_pixels - 1);
            end
            if (count > RANDOM_PIXELS - random_sent) begin
               count = RANDOM_PIXELS - random_sent;
            end
            for (int i = 0; i < count; i++) begin
               send_pixel(random_channel(), random_channel(), random_channel());
               if (!hold_armed) begin
                  hold_request = 1'b1;
                  hold_armed   = 1'b1;
               end
            end
            random_sent += count;
         end
      end
      steady = 1'b0;

      // Sizes above the maximum act as the maximum. Only the start of such a
      // frame is sent: part of an even row at the widest setting, then a
      // column of single blocks at the tallest one.
      set_size(REG_HALF_WIDTH, CSR_DATA_W'(10'h3FF));
      set_size(REG_HALF_HEIGHT, CSR_DATA_W'(1));
      send_random_pixels(32);
      set_size(REG_HALF_WIDTH, CSR_DATA_W'(1));
      set_size(REG_HALF_HEIGHT, CSR_DATA_W'(10'h3FF));
      send_random_pixels(40);

      finish_traffic();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("rgb_box_downscale_2x2_unit_test: clean");
      end else begin
         $display("rgb_box_downscale_2x2_unit_test: errors");
      end
      $finish;
   end

endmodule
